@@ rtl/core/mbps_pkg.sv @@
// ----------------------------------------------------------------------------
// mbps_pkg: shared types and constants of the masked byte pattern scan
// Field widths, configuration register indexes, queue entry and config bundle.
// ----------------------------------------------------------------------------
package mbps_pkg;

	// window and pattern sizes
	localparam int MAX_PATTERN_BYTES = 32;
	localparam int PATTERN_REG_BYTES = 32;
	localparam int LEN_CAP = (MAX_PATTERN_BYTES < PATTERN_REG_BYTES) ?
		MAX_PATTERN_BYTES : PATTERN_REG_BYTES;
	localparam int LEN_W = $clog2(LEN_CAP + 1);
	localparam int SHIFT_W = (LEN_CAP > 1) ? $clog2(LEN_CAP) : 1;

	// payload widths
	localparam int BYTE_W = 8;
	localparam int ADDR_W = 32;

	// configuration port
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 64;
	localparam int PLEN_W = 6;
	localparam int OFFSET_W = 8;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW      = 4'd0,
		REG_PATTERN_MID_LOW  = 4'd1,
		REG_PATTERN_MID_HIGH = 4'd2,
		REG_PATTERN_HIGH     = 4'd3,
		REG_CARE_MASK        = 4'd4,
		REG_PATTERN_LENGTH   = 4'd5,
		REG_SCAN_BASE        = 4'd6,
		REG_RESULT_OFFSET    = 4'd7
	} cfg_reg_t;

	// configuration register bundle
	typedef struct packed {
		logic [PATTERN_REG_BYTES*BYTE_W-1:0] pattern;
		logic [PATTERN_REG_BYTES-1:0]        care_mask;
		logic [PLEN_W-1:0]                   pattern_length;
		logic [ADDR_W-1:0]                   scan_base;
		logic [OFFSET_W-1:0]                 result_offset;
	} cfg_t;

	// one classified byte, handed from front to back
	typedef struct packed {
		logic              hit;
		logic              last;
		logic [ADDR_W-1:0] start;
	} scan_entry_t;

endpackage

@@ rtl/core/mbps_byte_if.sv @@
// ----------------------------------------------------------------------------
// mbps_byte_if: byte stream channel
// Valid/ready channel carrying one streamed byte and its end-of-range mark.
// ----------------------------------------------------------------------------
interface mbps_byte_if import mbps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ rtl/core/mbps_result_if.sv @@
// ----------------------------------------------------------------------------
// mbps_result_if: scan result channel
// Valid/ready channel carrying the found flag and the match address.
// ----------------------------------------------------------------------------
interface mbps_result_if import mbps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              found;
	logic [ADDR_W-1:0] match_address;

	modport source (output valid, output found, output match_address, input ready);
	modport sink (input valid, input found, input match_address, output ready);
endinterface

@@ rtl/core/mbps_front.sv @@
// ----------------------------------------------------------------------------
// mbps_front: byte window and parallel pattern compare
// Shifts accepted bytes into the window, then compares every window position
// against the length-aligned masked pattern and hands the entry, with its hit flag, onward.
// ----------------------------------------------------------------------------
module mbps_front import mbps_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	mbps_byte_if.sink       byte_in,
	output logic            push,
	output scan_entry_t     push_entry,
	input  logic            queue_full
);

	logic [BYTE_W-1:0]                   window_q [MAX_PATTERN_BYTES];
	logic [ADDR_W-1:0]                   seen_q;
	logic                                clr_q;
	logic                                v_s1;
	logic                                last_s1;
	logic                                take;
	logic [LEN_W-1:0]                    len;
	logic [LEN_W:0]                      sh_full;
	logic [SHIFT_W-1:0]                  sh;
	logic [PATTERN_REG_BYTES*BYTE_W-1:0] pat_rev;
	logic [PATTERN_REG_BYTES-1:0]        mask_rev;
	logic [PATTERN_REG_BYTES*BYTE_W-1:0] pat_al;
	logic [PATTERN_REG_BYTES-1:0]        mask_al;
	logic                                match;
	logic [ADDR_W-1:0]                   len_ext;

	// stage 1 moves on when the queue takes its entry
	assign push = v_s1 && !queue_full;
	assign take = byte_in.valid && byte_in.ready;
	assign byte_in.ready = !v_s1 || push;

	// effective pattern length, clamped to 1..LEN_CAP
	always_comb begin
		if (cfg.pattern_length == '0) begin
			len = LEN_W'(1);
		end else if (32'(cfg.pattern_length) > LEN_CAP) begin
			len = LEN_W'(LEN_CAP);
		end else begin
			len = LEN_W'(cfg.pattern_length);
		end
		sh_full = (LEN_W+1)'(PATTERN_REG_BYTES) - (LEN_W+1)'(len);
		sh = sh_full[SHIFT_W-1:0];
		len_ext = ADDR_W'(len);
	end

	// reverse the pattern, then shift so pattern byte len-1-j lines up with window j
	always_comb begin
		for (int j = 0; j < PATTERN_REG_BYTES; j++) begin
			pat_rev[BYTE_W*j +: BYTE_W] =
				cfg.pattern[BYTE_W*(PATTERN_REG_BYTES-1-j) +: BYTE_W];
			mask_rev[j] = cfg.care_mask[PATTERN_REG_BYTES-1-j];
		end
		pat_al = pat_rev >> {sh, 3'b000};
		mask_al = mask_rev >> sh;
	end

	// masked compare of all window positions at once
	always_comb begin
		match = seen_q >= len_ext;
		for (int j = 0; j < LEN_CAP; j++) begin
			if (mask_al[j] && (window_q[j] != pat_al[BYTE_W*j +: BYTE_W])) begin
				match = 1'b0;
			end
		end
		push_entry.hit = match;
		push_entry.last = last_s1;
		push_entry.start = seen_q - len_ext;
	end

	// window shift; stale bytes after a range end sit beyond the seen count
	always_ff @(posedge clk) begin
		if (take) begin
			window_q[0] <= byte_in.data_byte;
			for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
				window_q[i] <= window_q[i-1];
			end
		end
	end

	// byte count, range restart and stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			clr_q <= 1'b0;
			v_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			if (take) begin
				if (clr_q) begin
					seen_q <= ADDR_W'(1);
				end else if (seen_q != '1) begin
					seen_q <= seen_q + ADDR_W'(1);
				end
				clr_q <= byte_in.last_byte;
				last_s1 <= byte_in.last_byte;
				v_s1 <= 1'b1;
			end else if (push) begin
				v_s1 <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/mbps_queue.sv @@
// ----------------------------------------------------------------------------
// mbps_queue: short entry queue
// Two-entry first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module mbps_queue import mbps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  scan_entry_t push_entry,
	output logic        full,
	input  logic        pop,
	output logic        not_empty,
	output scan_entry_t head
);

	scan_entry_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QPTR_W:0]    count_q;

	assign full = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head = mem_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (32'(wr_q) == QUEUE_DEPTH - 1) ? '0 : wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= (32'(rd_q) == QUEUE_DEPTH - 1) ? '0 : rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

@@ rtl/core/mbps_back.sv @@
// ----------------------------------------------------------------------------
// mbps_back: result decision and output register
// Tracks whether the range already reported a match, forms the address and
// holds the result until the sink takes it.
// ----------------------------------------------------------------------------
module mbps_back import mbps_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  logic            not_empty,
	input  scan_entry_t     head,
	output logic            pop,
	mbps_result_if.source   result_out
);

	logic              done_q;
	logic              out_v_q;
	logic              found_q;
	logic [ADDR_W-1:0] addr_q;
	logic              emit_hit;
	logic              emit_miss;
	logic              emit;
	logic              out_free;
	logic [ADDR_W-1:0] addr_c;

	// decision for the head entry
	always_comb begin
		emit_hit = !done_q && head.hit;
		emit_miss = !done_q && !head.hit && head.last;
		emit = emit_hit || emit_miss;
		out_free = !out_v_q || result_out.ready;
		pop = not_empty && (!emit || out_free);
		addr_c = cfg.scan_base + head.start + ADDR_W'(cfg.result_offset);
	end

	assign result_out.valid = out_v_q;
	assign result_out.found = found_q;
	assign result_out.match_address = addr_q;

	// result payload
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			found_q <= emit_hit;
			addr_q <= emit_hit ? addr_c : '0;
		end
	end

	// range state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (pop) begin
				if (head.last) begin
					done_q <= 1'b0;
				end else if (emit_hit) begin
					done_q <= 1'b1;
				end
			end
			if (pop && emit) begin
				out_v_q <= 1'b1;
			end else if (result_out.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/masked_byte_pattern_scan_core.sv @@
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_core: masked byte pattern scan, top level
// Holds the configuration registers and joins front, queue and back.
//
//   port        dir   contents
//   byte_in     sink  data_byte, last_byte
//   result_out  src   found, match_address
//   cfg_*       in    write enable, register index, 64-bit write data
//
// One byte per cycle while the output does not stall; a byte's result passes the
// front's stage register, the queue and the output register before it is offered.
// The front compares all window positions at once; the back decides combinationally.
// Reset clears the window count, output valid and registers (pattern length 1).
// Output stalls back up through the two-entry queue before the input stalls.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan_core import mbps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	mbps_byte_if.sink             byte_in,
	mbps_result_if.source         result_out
);

	cfg_t        cfg_q;
	logic        push;
	logic        full;
	logic        pop;
	logic        not_empty;
	scan_entry_t push_entry;
	scan_entry_t head;

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern <= '0;
			cfg_q.care_mask <= '0;
			cfg_q.pattern_length <= PLEN_W'(1);
			cfg_q.scan_base <= '0;
			cfg_q.result_offset <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN_LOW: cfg_q.pattern[0 +: CFG_DATA_W] <= cfg_data;
				REG_PATTERN_MID_LOW: cfg_q.pattern[CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				REG_PATTERN_MID_HIGH: cfg_q.pattern[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				REG_PATTERN_HIGH: cfg_q.pattern[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				REG_CARE_MASK: cfg_q.care_mask <= cfg_data[PATTERN_REG_BYTES-1:0];
				REG_PATTERN_LENGTH: cfg_q.pattern_length <= cfg_data[PLEN_W-1:0];
				REG_SCAN_BASE: cfg_q.scan_base <= cfg_data[ADDR_W-1:0];
				REG_RESULT_OFFSET: cfg_q.result_offset <= cfg_data[OFFSET_W-1:0];
				default: begin
				end
			endcase
		end
	end

	mbps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.byte_in    (byte_in),
		.push       (push),
		.push_entry (push_entry),
		.queue_full (full)
	);

	mbps_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.not_empty  (not_empty),
		.head       (head)
	);

	mbps_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.not_empty  (not_empty),
		.head       (head),
		.pop        (pop),
		.result_out (result_out)
	);

endmodule
